### rtl/core/bvc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvc_pkg: shared types and constants of the base-128 varint codec
// Field widths, function and kind codes, controller states and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package bvc_pkg;

  localparam int unsigned VALUE_W   = 64;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned GRP_W     = 7;
  // 64 bits need ten 7-bit groups
  localparam int unsigned NUM_GRPS  = (VALUE_W + GRP_W - 1) / GRP_W;
  localparam int unsigned CNT_W     = $clog2(NUM_GRPS + 1);
  localparam int unsigned GRP_IDX_W = $clog2(NUM_GRPS);
  localparam int unsigned PAD_W     = NUM_GRPS * GRP_W - VALUE_W;

  // function codes
  localparam logic FUNC_ENCODE = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  // result kinds
  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_VALUE = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load_enc;   // load value and group count for encoding
    logic dec_step;   // shift a byte into the accumulator
    logic emit_byte;  // put the next encoded byte in the output register
  } cmd_t;

  typedef struct packed {
    logic out_free;   // output register empty or being taken this cycle
    logic last_grp;   // only one encoded byte remains
  } status_t;

endpackage

### rtl/core/bvc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvc_in_if / bvc_out_if: valid/ready channels of the varint codec
// One interface for input items, one for result items.
// ----------------------------------------------------------------------------
interface bvc_in_if import bvc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                func;
  logic [VALUE_W-1:0]  value_in;
  logic [BYTE_W-1:0]   byte_in;
  logic                zigzag;
  logic                buffer_end;

  modport source (output valid, func, value_in, byte_in, zigzag, buffer_end,
                  input ready);
  modport sink   (input valid, func, value_in, byte_in, zigzag, buffer_end,
                  output ready);
endinterface

interface bvc_out_if import bvc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                kind;
  logic [BYTE_W-1:0]   byte_out;
  logic [VALUE_W-1:0]  value_out;
  logic                last;

  modport source (output valid, kind, byte_out, value_out, last, input ready);
  modport sink   (input valid, kind, byte_out, value_out, last, output ready);
endinterface

### rtl/core/base128_varint_codec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base128_varint_codec: base-128 varint encoder/decoder, MSB group first
// Encodes 64-bit values into 1 to 10 bytes and decodes byte streams back,
// with optional zigzag mapping for signed values.
// ----------------------------------------------------------------------------
// Each decode byte is shifted into the accumulator as it is accepted, and
// a completing byte puts the value into the output register, so bytes can
// stream at one per cycle while the output drains. An encode item with n
// groups (1 to 10) occupies the block for one step that takes the value
// and counts its groups, then one step per byte, since the single output
// register sends one byte per cycle. Backpressure on the result channel
// stretches either case. No clearing pass after reset.
module base128_varint_codec import bvc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  bvc_in_if.sink    in_if,
  bvc_out_if.source out_if
);

  cmd_t    cmd;
  status_t stat;
  logic    in_ready;

  // sequence items
  bvc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_func  (in_if.func),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // hold and transform data
  bvc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .value_in   (in_if.value_in),
    .byte_in    (in_if.byte_in),
    .zigzag     (in_if.zigzag),
    .buffer_end (in_if.buffer_end),
    .out_ready  (out_if.ready),
    .stat       (stat),
    .out_valid  (out_if.valid),
    .out_kind   (out_if.kind),
    .out_byte   (out_if.byte_out),
    .out_value  (out_if.value_out),
    .out_last   (out_if.last)
  );

  assign in_if.ready = in_ready;

endmodule

### rtl/core/bvc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvc_ctrl: controller of the varint codec
// Takes input items, sequences the encoded bytes of an encode item and
// issues commands to the datapath.
// ----------------------------------------------------------------------------
module bvc_ctrl import bvc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_func,
  input  status_t stat,
  output logic    in_ready,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   accept;

  assign accept = in_valid && in_ready;

  // advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_func == FUNC_ENCODE) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free && stat.last_grp) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready     = stat.out_free;
        cmd.load_enc = accept && in_func == FUNC_ENCODE;
        cmd.dec_step = accept && in_func == FUNC_DECODE;
      end
      ST_EMIT: begin
        cmd.emit_byte = stat.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

### rtl/core/bvc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvc_dp: datapath of the varint codec
// Holds the decode accumulator, the value being encoded with its byte
// count, and the output register.
// ----------------------------------------------------------------------------
module bvc_dp import bvc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  input  logic [VALUE_W-1:0] value_in,
  input  logic [BYTE_W-1:0]  byte_in,
  input  logic               zigzag,
  input  logic               buffer_end,
  input  logic               out_ready,
  output status_t            stat,
  output logic               out_valid,
  output logic               out_kind,
  output logic [BYTE_W-1:0]  out_byte,
  output logic [VALUE_W-1:0] out_value,
  output logic               out_last
);

  logic [VALUE_W-1:0]   acc_r, acc_nxt;
  logic [VALUE_W-1:0]   shift_r;
  logic [CNT_W-1:0]     left_r, left_nxt;
  logic                 valid_r, valid_nxt;
  logic                 kind_r;
  logic [BYTE_W-1:0]    byte_r;
  logic [VALUE_W-1:0]   value_r;
  logic                 last_r;

  logic [VALUE_W-1:0]   enc_val;
  logic [CNT_W-1:0]     enc_cnt;
  logic [NUM_GRPS*GRP_W-1:0] ext_val;
  logic [GRP_W-1:0]     grp_a [NUM_GRPS];
  logic [GRP_IDX_W-1:0] grp_idx;
  logic [GRP_W-1:0]     grp_sel;
  logic [VALUE_W-1:0]   acc_shl;
  logic [VALUE_W-1:0]   dec_val;
  logic                 dec_done;

  // fold signed value for encoding
  assign enc_val = zigzag ? ({value_in[VALUE_W-2:0], 1'b0} ^ {VALUE_W{value_in[VALUE_W-1]}})
                          : value_in;

  // count groups: highest nonzero 7-bit group plus one
  always_comb begin
    logic [GRP_W*NUM_GRPS-1:0] ev;
    ev      = {{PAD_W{1'b0}}, enc_val};
    enc_cnt = CNT_W'(1);
    for (int i = 1; i < NUM_GRPS; i++) begin
      if (|ev[i*GRP_W +: GRP_W]) begin
        enc_cnt = CNT_W'(i + 1);
      end
    end
  end

  // split held value into groups and pick the current one
  assign ext_val = {{PAD_W{1'b0}}, shift_r};
  always_comb begin
    for (int i = 0; i < NUM_GRPS; i++) begin
      grp_a[i] = ext_val[i*GRP_W +: GRP_W];
    end
  end
  assign grp_idx = GRP_IDX_W'(left_r - CNT_W'(1));
  assign grp_sel = grp_a[grp_idx];

  // shift a byte into the accumulator and unfold on completion
  assign acc_shl  = {acc_r[VALUE_W-GRP_W-1:0], byte_in[GRP_W-1:0]};
  assign dec_done = !byte_in[BYTE_W-1] || buffer_end;
  assign dec_val  = zigzag ? ({1'b0, acc_shl[VALUE_W-1:1]} ^ {VALUE_W{acc_shl[0]}})
                           : acc_shl;

  // status to the controller
  assign stat.out_free = !valid_r || out_ready;
  assign stat.last_grp = (left_r == CNT_W'(1));

  // next accumulator, byte count and output valid
  always_comb begin
    acc_nxt   = acc_r;
    left_nxt  = left_r;
    valid_nxt = valid_r && !out_ready;
    if (cmd.dec_step) begin
      acc_nxt = dec_done ? '0 : acc_shl;
      if (dec_done) begin
        valid_nxt = 1'b1;
      end
    end
    if (cmd.load_enc) begin
      left_nxt = enc_cnt;
    end
    if (cmd.emit_byte) begin
      left_nxt  = left_r - CNT_W'(1);
      valid_nxt = 1'b1;
    end
  end

  // hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      left_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      acc_r   <= acc_nxt;
      left_r  <= left_nxt;
      valid_r <= valid_nxt;
    end
  end

  // load encode value and output payload
  always_ff @(posedge clk) begin
    if (cmd.load_enc) begin
      shift_r <= enc_val;
    end
    if (cmd.dec_step && dec_done) begin
      kind_r  <= KIND_VALUE;
      byte_r  <= '0;
      value_r <= dec_val;
      last_r  <= 1'b1;
    end else if (cmd.emit_byte) begin
      kind_r  <= KIND_BYTE;
      byte_r  <= {!stat.last_grp, grp_sel};
      value_r <= '0;
      last_r  <= stat.last_grp;
    end
  end

  assign out_valid = valid_r;
  assign out_kind  = kind_r;
  assign out_byte  = byte_r;
  assign out_value = value_r;
  assign out_last  = last_r;

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the base-128 varint codec
// Drives encode values and decode byte streams through the valid/ready
// channels, predicts every encoded byte and decoded value in a scoreboard
// object, and compares each accepted result in order, under random idling
// on both sides, a long output stall and a full drain.
// ----------------------------------------------------------------------------
module tb_top;
  import bvc_pkg::*;

  typedef struct {
    logic               func;
    logic [VALUE_W-1:0] value_in;
    logic [BYTE_W-1:0]  byte_in;
    logic               zigzag;
    logic               buffer_end;
  } codec_item_t;

  typedef struct {
    logic               kind;
    logic [BYTE_W-1:0]  byte_out;
    logic [VALUE_W-1:0] value_out;
    logic               last;
  } codec_result_t;

  // Scoreboard: tracks the decode accumulator and the results still owed
  class varint_book;
    logic [VALUE_W-1:0] acc;
    codec_result_t      awaited[$];
    int unsigned        faults;

    function new();
      acc    = '0;
      faults = 0;
    endfunction

    function void flag(string msg);
      faults++;
      if (faults <= 10) $display("%s", msg);
    endfunction

    // Work out the results one accepted item causes
    function void note_item(codec_item_t it);
      logic [VALUE_W-1:0] v;
      logic [VALUE_W-1:0] t;
      logic [BYTE_W-1:0]  grp;
      int                 ngrp;
      codec_result_t      r;
      if (it.func == FUNC_ENCODE) begin
        v = it.zigzag ? ((it.value_in << 1) ^ {VALUE_W{it.value_in[VALUE_W-1]}})
                      : it.value_in;
        ngrp = 1;
        t = v;
        while (t >= 128) begin
          t = t >> 7;
          ngrp++;
        end
        // emit groups most significant first
        for (int i = ngrp - 1; i >= 0; i--) begin
          grp = BYTE_W'(v >> (7 * i)) & 8'h7f;
          r.kind      = KIND_BYTE;
          r.byte_out  = (i == 0) ? grp : (grp | 8'h80);
          r.value_out = '0;
          r.last      = (i == 0);
          awaited.push_back(r);
        end
      end else begin
        acc = (acc << 7) + {{(VALUE_W-7){1'b0}}, it.byte_in[6:0]};
        if (!it.byte_in[7] || it.buffer_end) begin
          v = it.zigzag ? ((acc >> 1) ^ ({VALUE_W{1'b0}} - {{(VALUE_W-1){1'b0}}, acc[0]}))
                        : acc;
          acc = '0;
          r.kind      = KIND_VALUE;
          r.byte_out  = '0;
          r.value_out = v;
          r.last      = 1'b1;
          awaited.push_back(r);
        end
      end
    endfunction

    // Compare one accepted result with the oldest one owed
    function void check_item(codec_result_t got);
      codec_result_t want;
      if (awaited.size() == 0) begin
        flag($sformatf("unexpected result: kind %0d byte %02h value %016h last %0d",
                       got.kind, got.byte_out, got.value_out, got.last));
        return;
      end
      want = awaited.pop_front();
      if (got.kind !== want.kind || got.byte_out !== want.byte_out ||
          got.value_out !== want.value_out || got.last !== want.last)
        flag($sformatf({"mismatch: kind %0d/%0d byte %02h/%02h value %016h/%016h ",
                        "last %0d/%0d (expected/actual)"},
                       want.kind, got.kind, want.byte_out, got.byte_out,
                       want.value_out, got.value_out, want.last, got.last));
    endfunction

    function int unsigned waiting();
      return awaited.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  bvc_in_if  in_ch ();
  bvc_out_if out_ch ();

  base128_varint_codec dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  varint_book  book = new();
  int unsigned in_idle_pct  = 35;
  int unsigned out_idle_pct = 51;
  int unsigned hold_request = 0;
  int unsigned hold_left    = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Give up after a generous fixed time
  initial begin
    #2_000_000;
    $display("base128_varint_codec test failed");
    $finish;
  end

  // Receiver: check accepted results, then idle or hold off
  initial begin
    codec_result_t got;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.kind      = out_ch.kind;
        got.byte_out  = out_ch.byte_out;
        got.value_out = out_ch.value_out;
        got.last      = out_ch.last;
        book.check_item(got);
      end
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  function automatic codec_item_t enc_item(logic [VALUE_W-1:0] v, logic zz);
    codec_item_t it;
    it.func       = FUNC_ENCODE;
    it.value_in   = v;
    it.byte_in    = BYTE_W'($urandom);
    it.zigzag     = zz;
    it.buffer_end = 1'($urandom);
    return it;
  endfunction

  function automatic codec_item_t dec_item(logic [BYTE_W-1:0] b, logic zz, logic be);
    codec_item_t it;
    it.func       = FUNC_DECODE;
    it.value_in   = {$urandom, $urandom};
    it.byte_in    = b;
    it.zigzag     = zz;
    it.buffer_end = be;
    return it;
  endfunction

  // Random value of random bit length, so short encodings are common
  function automatic logic [VALUE_W-1:0] rand_value();
    logic [VALUE_W-1:0] v;
    int unsigned        w;
    v = {$urandom, $urandom};
    w = $urandom_range(VALUE_W);
    if (w < VALUE_W) v = v & ((64'd1 << w) - 64'd1);
    return v;
  endfunction

  // Offer one item, idling first at random, and hold it until accepted
  task automatic send_item(codec_item_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= it.func;
    in_ch.value_in   <= it.value_in;
    in_ch.byte_in    <= it.byte_in;
    in_ch.zigzag     <= it.zigzag;
    in_ch.buffer_end <= it.buffer_end;
    do @(posedge clk); while (!in_ch.ready);
    book.note_item(it);
  endtask

  // Drop valid and wait until every owed result has come
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (book.waiting() != 0);
  endtask

  task automatic directed_items();
    // encode extremes, with and without zigzag
    send_item(enc_item(64'd0, 1'b0));
    send_item(enc_item(64'd127, 1'b0));
    send_item(enc_item(64'd128, 1'b0));
    send_item(enc_item(64'hffff_ffff_ffff_ffff, 1'b0));
    send_item(enc_item(64'h8000_0000_0000_0000, 1'b0));
    send_item(enc_item(64'hffff_ffff_ffff_ffff, 1'b1));
    send_item(enc_item(64'h7fff_ffff_ffff_ffff, 1'b1));
    send_item(enc_item(64'h8000_0000_0000_0000, 1'b1));
    // single-byte decodes, plain and zigzag
    send_item(dec_item(8'h00, 1'b0, 1'b0));
    send_item(dec_item(8'h7f, 1'b1, 1'b0));
    // encode in the middle of a pending decode
    send_item(dec_item(8'h81, 1'b1, 1'b0));
    send_item(enc_item(64'd300, 1'b0));
    send_item(dec_item(8'h00, 1'b0, 1'b0));
    // buffer end forces completion on a continuation byte
    send_item(dec_item(8'hff, 1'b0, 1'b1));
    // seventy data bits wrap the accumulator
    repeat (9) send_item(dec_item(8'hff, 1'b0, 1'b0));
    send_item(dec_item(8'h7f, 1'b1, 1'b0));
    send_item(dec_item(8'h80, 1'b1, 1'b1));
  endtask

  // Mostly well-formed encodes and byte streams, some broken streams and noise
  task automatic random_items(int unsigned count);
    int unsigned       sent;
    int unsigned       sel;
    int unsigned       len;
    logic [BYTE_W-1:0] b;
    logic              be;
    sent = 0;
    while (sent < count) begin
      sel = $urandom_range(99);
      if (sel < 40) begin
        send_item(enc_item(rand_value(), 1'($urandom)));
        sent++;
      end else if (sel < 85) begin
        len = ($urandom_range(3) == 0) ? $urandom_range(1, 11) : $urandom_range(1, 4);
        for (int k = 0; k < len; k++) begin
          b  = BYTE_W'($urandom);
          be = 1'b0;
          if (k < len - 1) begin
            b[7] = 1'b1;
            // cut the stream short now and then
            if ($urandom_range(19) == 0) be = 1'b1;
          end else begin
            b[7] = 1'b0;
            be   = ($urandom_range(3) == 0);
          end
          if ($urandom_range(29) == 0) begin
            send_item(enc_item(rand_value(), 1'($urandom)));
            sent++;
          end
          send_item(dec_item(b, 1'($urandom), be));
          sent++;
          if (be) break;
        end
      end else begin
        send_item(dec_item(BYTE_W'($urandom), 1'($urandom), ($urandom_range(4) == 0)));
        sent++;
      end
    end
  endtask

  // Main sequence
  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.func       <= FUNC_ENCODE;
    in_ch.value_in   <= '0;
    in_ch.byte_in    <= '0;
    in_ch.zigzag     <= 1'b0;
    in_ch.buffer_end <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // sender idles less than receiver
    in_idle_pct  = 35;
    out_idle_pct = 51;
    directed_items();
    random_items(110);
    wait_drained();

    // receiver idles less than sender
    in_idle_pct  = 51;
    out_idle_pct = 35;
    random_items(110);
    wait_drained();

    // no idling; hold the output off so the block backs up its input
    in_idle_pct  = 0;
    out_idle_pct = 0;
    hold_request = 250;
    random_items(100);

    wait_drained();
    repeat (20) @(posedge clk);
    if (book.faults == 0 && book.waiting() == 0) begin
      $display("base128_varint_codec test passed");
    end else begin
      $display("base128_varint_codec test failed");
    end
    $finish;
  end

endmodule
